// ===== hw/rtl/modified_utf8_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// modified utf-8 decoder assertion macros
// ----------------------------------------------------------------------------
`ifndef MODIFIED_UTF8_DECODER_DEFINES_SVH
`define MODIFIED_UTF8_DECODER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define MU8D_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define MU8D_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mu8d_pkg.sv =====
// ----------------------------------------------------------------------------
// mu8d_pkg
// types and codes shared by the modified utf-8 decoder modules
// ----------------------------------------------------------------------------
package mu8d_pkg;

	localparam int CpW = 21;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_FORBIDDEN = 2'd1;
	localparam logic [1:0] ERR_MALFORMED = 2'd2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_end;
	} in_item_t;

	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic [1:0]     error_kind;
		logic           end_of_string;
	} out_item_t;

	// what a byte means when it stands in lead position
	typedef enum logic [2:0] {
		LEAD_FORBID,
		LEAD_ASCII,
		LEAD_STRAY,
		LEAD_TWO,
		LEAD_THREE
	} lead_kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       is_end;
		lead_kind_t lead;
		logic       is_cont;
		logic       is_ed;
		logic       is_ax;
		logic       is_bx;
	} cls_t;

endpackage

// ===== hw/rtl/mu8d_fifo.sv =====
// ----------------------------------------------------------------------------
// mu8d_fifo
// small register fifo with valid/ready on both sides
// ----------------------------------------------------------------------------
module mu8d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CntW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/mu8d_front.sv =====
// ----------------------------------------------------------------------------
// mu8d_front
// takes input bytes and tags them with their lead and continuation classes
// ----------------------------------------------------------------------------
module mu8d_front (
	input  logic               item_valid,
	output logic               item_ready,
	input  mu8d_pkg::in_item_t item,
	output logic               cls_valid,
	input  logic               cls_ready,
	output mu8d_pkg::cls_t     cls
);
	import mu8d_pkg::*;

	logic [7:0] b;

	assign b          = item.byte_value;
	assign item_ready = cls_ready;
	assign cls_valid  = item_valid;

	always_comb begin
		cls.byte_value = b;
		cls.is_end     = item.is_end;
		cls.is_cont    = (b[7:6] == 2'b10);
		cls.is_ed      = (b == 8'hed);
		cls.is_ax      = (b[7:4] == 4'ha);
		cls.is_bx      = (b[7:4] == 4'hb);
		priority if (b == 8'h00 || b[7:4] == 4'hf) begin
			cls.lead = LEAD_FORBID;
		end else if (!b[7]) begin
			cls.lead = LEAD_ASCII;
		end else if (b[7:6] == 2'b10) begin
			cls.lead = LEAD_STRAY;
		end else if (b[7:5] == 3'b110) begin
			cls.lead = LEAD_TWO;
		end else begin
			cls.lead = LEAD_THREE;
		end
	end

endmodule

// ===== hw/rtl/mu8d_back.sv =====
// ----------------------------------------------------------------------------
// mu8d_back
// sequence decoder: tracks the held prefix and emits code points and errors
// ----------------------------------------------------------------------------
module mu8d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cls_valid,
	output logic                cls_ready,
	input  mu8d_pkg::cls_t      cls,
	output logic                res_valid,
	input  logic                res_ready,
	output mu8d_pkg::out_item_t res
);
	import mu8d_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TWO1,
		ST_THREE1,
		ST_THREE2,
		ST_ED1,
		ST_PAIR2,
		ST_PAIR3,
		ST_PAIR4,
		ST_PAIR5
	} state_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} step_t;

	function automatic step_t f_none();
		step_t s;
		s = '0;
		return s;
	endfunction

	function automatic step_t f_emit(logic [CpW-1:0] cp);
		step_t s;
		s.valid              = 1'b1;
		s.item.code_point    = cp;
		s.item.error_kind    = ERR_NONE;
		s.item.end_of_string = 1'b0;
		return s;
	endfunction

	function automatic step_t f_err(logic [1:0] kind);
		step_t s;
		s.valid              = 1'b1;
		s.item.code_point    = '0;
		s.item.error_kind    = kind;
		s.item.end_of_string = 1'b1;
		return s;
	endfunction

	state_t    state_q;
	logic      skip_q;
	logic      pend_valid_q;
	out_item_t pend_q;
	logic [4:0] lead_q;
	logic [5:0] b1_q;
	logic [5:0] b2_q;
	logic [3:0] b4_q;

	state_t nxt;
	state_t ls_nxt;
	state_t es_nxt;
	step_t  ls;
	step_t  es;
	step_t  r0;
	step_t  r1;
	logic   fin;
	logic   take;
	logic   got_err;
	logic [4:0]     pair_plane;
	logic [CpW-1:0] held3_cp;
	logic [CpW-1:0] three_cp;
	logic [CpW-1:0] two_cp;
	logic [CpW-1:0] pair_cp;

	assign fin        = cls.is_end;
	assign cls_ready  = !pend_valid_q && res_ready;
	assign take       = cls_valid && cls_ready;
	assign pair_plane = {1'b0, b1_q[3:0]} + 5'd1;
	assign held3_cp   = {5'd0, lead_q[3:0], b1_q, b2_q};
	assign three_cp   = {5'd0, lead_q[3:0], b1_q, cls.byte_value[5:0]};
	assign two_cp     = {10'd0, lead_q, cls.byte_value[5:0]};
	assign pair_cp    = {pair_plane, b2_q, b4_q, cls.byte_value[5:0]};

	// the byte taken as a fresh lead
	always_comb begin
		ls     = f_none();
		ls_nxt = ST_IDLE;
		unique case (cls.lead)
			LEAD_FORBID: ls = f_err(ERR_FORBIDDEN);
			LEAD_ASCII: ls = f_emit({14'd0, cls.byte_value[6:0]});
			LEAD_STRAY: ls = f_err(ERR_MALFORMED);
			LEAD_TWO: begin
				if (fin) begin
					ls = f_err(ERR_MALFORMED);
				end else begin
					ls_nxt = ST_TWO1;
				end
			end
			LEAD_THREE: begin
				if (fin) begin
					ls = f_err(ERR_MALFORMED);
				end else begin
					ls_nxt = cls.is_ed ? ST_ED1 : ST_THREE1;
				end
			end
			default: ls = f_err(ERR_MALFORMED);
		endcase
	end

	// the byte taken as second byte after an ed lead
	always_comb begin
		es     = f_none();
		es_nxt = ST_IDLE;
		priority if (!cls.is_cont || fin) begin
			es = f_err(ERR_MALFORMED);
		end else if (cls.is_ax) begin
			es_nxt = ST_PAIR2;
		end else begin
			es_nxt = ST_THREE2;
		end
	end

	always_comb begin
		r0  = f_none();
		r1  = f_none();
		nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				r0  = ls;
				nxt = ls_nxt;
			end
			ST_TWO1: begin
				nxt = ST_IDLE;
				r0  = cls.is_cont ? f_emit(two_cp) : f_err(ERR_MALFORMED);
			end
			ST_THREE1: begin
				if (!cls.is_cont || fin) begin
					r0  = f_err(ERR_MALFORMED);
					nxt = ST_IDLE;
				end else begin
					nxt = ST_THREE2;
				end
			end
			ST_THREE2: begin
				nxt = ST_IDLE;
				r0  = cls.is_cont ? f_emit(three_cp) : f_err(ERR_MALFORMED);
			end
			ST_ED1: begin
				r0  = es;
				nxt = es_nxt;
			end
			ST_PAIR2: begin
				if (!cls.is_cont) begin
					r0  = f_err(ERR_MALFORMED);
					nxt = ST_IDLE;
				end else if (fin) begin
					r0  = f_emit(three_cp);
					nxt = ST_IDLE;
				end else begin
					nxt = ST_PAIR3;
				end
			end
			// pair broken: the held three bytes become a lone surrogate
			ST_PAIR3: begin
				if (cls.is_ed && !fin) begin
					nxt = ST_PAIR4;
				end else begin
					r0  = f_emit(held3_cp);
					r1  = ls;
					nxt = ls_nxt;
				end
			end
			ST_PAIR4: begin
				if (cls.is_bx && !fin) begin
					nxt = ST_PAIR5;
				end else begin
					r0  = f_emit(held3_cp);
					r1  = es;
					nxt = es_nxt;
				end
			end
			ST_PAIR5: begin
				nxt = ST_IDLE;
				if (cls.is_cont) begin
					r0 = f_emit(pair_cp);
				end else begin
					r0 = f_emit(held3_cp);
					r1 = f_err(ERR_MALFORMED);
				end
			end
			default: nxt = ST_IDLE;
		endcase
		if (fin) begin
			priority if (r1.valid) begin
				r1.item.end_of_string = 1'b1;
			end else if (r0.valid) begin
				r0.item.end_of_string = 1'b1;
			end
		end
		got_err = (r0.valid && r0.item.error_kind != ERR_NONE)
			|| (r1.valid && r1.item.error_kind != ERR_NONE);
	end

	assign res_valid = pend_valid_q || (cls_valid && !skip_q && r0.valid);
	assign res       = pend_valid_q ? pend_q : r0.item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			skip_q       <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q && res_ready) begin
				pend_valid_q <= 1'b0;
			end
			if (take) begin
				if (skip_q) begin
					if (fin) begin
						skip_q <= 1'b0;
					end
				end else begin
					state_q <= nxt;
					if (got_err && !fin) begin
						skip_q <= 1'b1;
					end
					if (r1.valid) begin
						pend_valid_q <= 1'b1;
					end
				end
			end
		end
	end

	// held sequence bytes, written as the state advances
	always_ff @(posedge clk) begin
		if (take && !skip_q) begin
			if (r1.valid) begin
				pend_q <= r1.item;
			end
			unique case (nxt)
				ST_TWO1, ST_THREE1, ST_ED1: lead_q <= cls.byte_value[4:0];
				ST_THREE2, ST_PAIR2: b1_q <= cls.byte_value[5:0];
				ST_PAIR3: b2_q <= cls.byte_value[5:0];
				ST_PAIR5: b4_q <= cls.byte_value[3:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/modified_utf8_decoder.sv =====
// ----------------------------------------------------------------------------
// modified_utf8_decoder
// path: a byte's result passes the registered input queue and then the registered
//   result queue before it is offered on the output
// throughput: one byte per cycle while the result queue has room; a byte that breaks a held
//   surrogate pair gives two results and holds the decoder until its second result is queued
// reset: clears queues, decoder state and the skip-after-error flag
// ----------------------------------------------------------------------------
`include "modified_utf8_decoder_defines.svh"

module modified_utf8_decoder #(
	parameter int QUEUE_DEPTH  = 2,
	parameter int RESULT_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mu8d_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output mu8d_pkg::out_item_t result
);
	import mu8d_pkg::*;

	localparam int ClsW = $bits(cls_t);
	localparam int ResW = $bits(out_item_t);

	cls_t      front_cls;
	logic      front_valid;
	logic      front_ready;
	cls_t      q_head;
	logic      q_valid;
	logic      q_ready;
	out_item_t back_res;
	logic      back_valid;
	logic      back_ready;

	mu8d_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cls_valid  (front_valid),
		.cls_ready  (front_ready),
		.cls        (front_cls)
	);

	mu8d_fifo #(
		.WIDTH (ClsW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cls),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_head)
	);

	mu8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_valid (q_valid),
		.cls_ready (q_ready),
		.cls       (q_head),
		.res_valid (back_valid),
		.res_ready (back_ready),
		.res       (back_res)
	);

	mu8d_fifo #(
		.WIDTH (ResW),
		.DEPTH (RESULT_DEPTH)
	) u_results (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (back_valid),
		.push_ready (back_ready),
		.push_data  (back_res),
		.pop_valid  (result_valid),
		.pop_ready  (result_ready),
		.pop_data   (result)
	);

	// an error result always closes the string and carries no code point
	`MU8D_ASSERT_IMPLY(a_err_closes, back_valid && back_res.error_kind != ERR_NONE, back_res.end_of_string && back_res.code_point == '0, "error result without end of string or with a code point")
	`MU8D_ASSERT_IMPLY(a_cp_range, back_valid, back_res.code_point <= 21'h10ffff, "code point out of range")
	`MU8D_ASSERT_IMPLY(a_err_code, result_valid, result.error_kind == ERR_NONE || result.error_kind == ERR_FORBIDDEN || result.error_kind == ERR_MALFORMED, "unknown error kind")

endmodule
